[rtl/bfsd_pkg.sv]
package bfsd_pkg;

  // Command classes passed from the front part to the back part
  typedef enum logic [1:0] {
    CMD_OPEN  = 2'd0,
    CMD_BIT   = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        bit_val;    // inverted-corrected raw bit (CMD_BIT)
    logic [10:0] raw_cnt;    // raw bits taken into the frame before this one
  } cmd_t;

  // Most bytes a single gap flush may emit
  localparam int unsigned MAX_FLUSH_BYTES = 17;

  // Width of the output byte-index field
  localparam int unsigned IDX_W = 6;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_SYNC   = 2'd0;
  localparam logic [1:0] REG_INVERT = 2'd1;
  localparam logic [1:0] REG_FLUSH  = 2'd2;

  // Input beat kinds (in_tuser)
  localparam logic FUNC_BIT = 1'b0;
  localparam logic FUNC_GAP = 1'b1;

endpackage

[rtl/bfsd_front.sv]
module bfsd_front import bfsd_pkg::*; #(
  parameter int unsigned FRAME_LEN = 48,
  parameter int unsigned SYNC_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        beat_valid,
  output logic        beat_ready,
  input  logic        func,
  input  logic        raw_bit,
  input  logic [31:0] sync_pattern,
  input  logic        invert_bits,
  input  logic [10:0] flush_threshold,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  localparam logic [10:0] RAW_LAST = 11'(FRAME_LEN * 16 - 1);
  localparam logic [10:0] FLUSH_FLOOR =
    11'((FRAME_LEN > MAX_FLUSH_BYTES) ? ((FRAME_LEN - MAX_FLUSH_BYTES) * 16) : 0);

  logic [SYNC_BITS-1:0] sync_r, sync_nxt;
  logic                 open_r, open_nxt;
  logic [10:0]          cnt_r, cnt_nxt;
  logic                 bit_c;
  logic                 take;
  logic [SYNC_BITS-1:0] want;

  assign beat_ready = cmd_ready;
  assign take       = beat_valid & beat_ready;
  assign bit_c      = raw_bit ^ invert_bits;
  assign want       = sync_pattern[SYNC_BITS-1:0];

  always_comb begin
    sync_nxt        = sync_r;
    open_nxt        = open_r;
    cnt_nxt         = cnt_r;
    cmd_valid       = 1'b0;
    cmd.kind        = CMD_BIT;
    cmd.bit_val     = bit_c;
    cmd.raw_cnt     = cnt_r;
    if (take) begin
      if (func == FUNC_GAP) begin
        // gap: flush only a frame far enough along
        if (open_r && (cnt_r > flush_threshold) && (cnt_r >= FLUSH_FLOOR)) begin
          cmd_valid = 1'b1;
          cmd.kind  = CMD_FLUSH;
          open_nxt  = 1'b0;
          cnt_nxt   = '0;
        end
      end else begin
        sync_nxt = {sync_r[SYNC_BITS-2:0], bit_c};
        if (!open_r) begin
          if ((sync_nxt == want) || (sync_nxt == ~want)) begin
            cmd_valid = 1'b1;
            cmd.kind  = CMD_OPEN;
            open_nxt  = 1'b1;
            cnt_nxt   = '0;
          end
        end else begin
          cmd_valid = 1'b1;
          cmd.kind  = CMD_BIT;
          if (cnt_r == RAW_LAST) begin
            open_nxt = 1'b0;
            cnt_nxt  = '0;
          end else begin
            cnt_nxt = cnt_r + 11'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= '0;
      open_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      sync_r <= sync_nxt;
      open_r <= open_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

[rtl/bfsd_fifo.sv]
module bfsd_fifo import bfsd_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push, pop;

  assign wr_ready = (cnt_r != CNT_FULL);
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid & wr_ready;
  assign pop      = rd_valid & rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PTR_LAST) ? '0 : wp_r + PTR_W'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == PTR_LAST) ? '0 : rp_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

[rtl/bfsd_back.sv]
module bfsd_back import bfsd_pkg::*; #(
  parameter int unsigned FRAME_LEN = 48,
  parameter int unsigned CHECK_POS = 45
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  cmd_t             cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] out_idx,
  output logic [7:0]       out_val,
  output logic             out_last,
  output logic             out_ok
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0] CHK_HI   = IDX_W'(CHECK_POS);
  localparam logic [IDX_W-1:0] CHK_LO   = IDX_W'(CHECK_POS + 1);

  typedef enum logic {ST_RUN, ST_FLUSH} state_t;

  // Linear 16-bit frame checksum, one byte per call
  function automatic logic [15:0] check_update(input logic [15:0] c, input logic [7:0] b);
    logic [7:0] br;
    logic [7:0] t;
    logic [7:0] s;
    br = {b[0], b[7:1]};
    br = br ^ (br >> 2);
    t  = {c[1] ^ c[3] ^ c[5], c[0] ^ c[2] ^ c[4], c[5:0]};
    s  = c[14:7];
    s  = s ^ (s >> 2);
    return {c[7:0], br ^ t ^ s};
  endfunction

  state_t           state_r, state_nxt;
  logic             pend_r, pend_nxt;
  logic [7:0]       bsh_r, bsh_nxt;
  logic [15:0]      rchk_r, rchk_nxt;
  logic [15:0]      xchk_r, xchk_nxt;
  logic [IDX_W-1:0] fl_idx_r, fl_idx_nxt;
  logic             ov_r, ov_nxt;
  logic [IDX_W-1:0] oidx_r, oidx_nxt;
  logic [7:0]       oval_r, oval_nxt;
  logic             olast_r, olast_nxt;
  logic             ook_r, ook_nxt;

  logic             can_emit;
  logic             emit;
  logic [IDX_W-1:0] e_idx;
  logic [7:0]       e_val;
  logic [IDX_W-1:0] c_idx;
  logic [2:0]       pairs;
  logic [8:0]       fl_odd;
  logic [7:0]       fl_even;
  logic [7:0]       fl_val;

  assign can_emit  = !ov_r || out_ready;
  assign cmd_ready = (state_r == ST_RUN) && can_emit;
  assign c_idx     = cmd.raw_cnt[9:4];

  // First byte of a flush: finish the open pair with a zero, pad with zeros
  assign pairs   = cmd.raw_cnt[3:1];
  assign fl_odd  = {bsh_r, pend_r} << (3'd7 - pairs);
  assign fl_even = bsh_r << (4'd8 - {1'b0, pairs});
  assign fl_val  = cmd.raw_cnt[0] ? fl_odd[7:0] : fl_even;

  always_comb begin
    state_nxt  = state_r;
    pend_nxt   = pend_r;
    bsh_nxt    = bsh_r;
    fl_idx_nxt = fl_idx_r;
    rchk_nxt   = rchk_r;
    xchk_nxt   = xchk_r;
    emit       = 1'b0;
    e_idx      = c_idx;
    e_val      = bsh_r;

    unique case (state_r)
      ST_RUN: begin
        if (cmd_valid && cmd_ready) begin
          unique case (cmd.kind)
            CMD_OPEN: begin
              pend_nxt = 1'b0;
              bsh_nxt  = '0;
              rchk_nxt = '0;
              xchk_nxt = '0;
            end
            CMD_BIT: begin
              if (!cmd.raw_cnt[0]) begin
                pend_nxt = cmd.bit_val;
              end else begin
                bsh_nxt = {bsh_r[6:0], pend_r ^ cmd.bit_val};
                if (cmd.raw_cnt[3:0] == 4'hF) begin
                  emit  = 1'b1;
                  e_val = bsh_nxt;
                end
              end
            end
            CMD_FLUSH: begin
              emit     = 1'b1;
              e_val    = fl_val;
              pend_nxt = 1'b0;
              bsh_nxt  = fl_val;
              if (c_idx != LAST_IDX) begin
                state_nxt  = ST_FLUSH;
                fl_idx_nxt = c_idx + IDX_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FLUSH: begin
        if (can_emit) begin
          emit       = 1'b1;
          e_idx      = fl_idx_r;
          e_val      = '0;
          bsh_nxt    = '0;
          fl_idx_nxt = fl_idx_r + IDX_W'(1);
          if (fl_idx_r == LAST_IDX) begin
            state_nxt = ST_RUN;
          end
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase

    if (emit) begin
      if (e_idx < CHK_HI) begin
        rchk_nxt = check_update(rchk_r, e_val);
      end
      if (e_idx == CHK_HI) begin
        xchk_nxt = {e_val, xchk_r[7:0]};
      end
      if (e_idx == CHK_LO) begin
        xchk_nxt = {xchk_r[15:8], e_val};
      end
    end
  end

  always_comb begin
    ov_nxt    = ov_r;
    oidx_nxt  = oidx_r;
    oval_nxt  = oval_r;
    olast_nxt = olast_r;
    ook_nxt   = ook_r;
    if (out_ready) begin
      ov_nxt = 1'b0;
    end
    if (emit) begin
      ov_nxt    = 1'b1;
      oidx_nxt  = e_idx;
      oval_nxt  = e_val;
      olast_nxt = (e_idx == LAST_IDX);
      ook_nxt   = (e_idx == LAST_IDX) && (rchk_nxt == xchk_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_RUN;
      ov_r     <= 1'b0;
      pend_r   <= 1'b0;
      bsh_r    <= '0;
      rchk_r   <= '0;
      xchk_r   <= '0;
      fl_idx_r <= '0;
    end else begin
      state_r  <= state_nxt;
      ov_r     <= ov_nxt;
      pend_r   <= pend_nxt;
      bsh_r    <= bsh_nxt;
      rchk_r   <= rchk_nxt;
      xchk_r   <= xchk_nxt;
      fl_idx_r <= fl_idx_nxt;
    end
    oidx_r  <= oidx_nxt;
    oval_r  <= oval_nxt;
    olast_r <= olast_nxt;
    ook_r   <= ook_nxt;
  end

  assign out_valid = ov_r;
  assign out_idx   = oidx_r;
  assign out_val   = oval_r;
  assign out_last  = olast_r;
  assign out_ok    = ook_r;

endmodule

[rtl/biphase_frame_sync_decoder.sv]
// Channel  | Dir | Ports                         | Beat contents
// in_      | in  | tvalid tready tdata tuser     | tdata[0] raw_bit; tuser func (1 = gap)
// out_     | out | tvalid tready tdata tlast tuser | tdata byte_index, byte_value;
//          |     |                               | tlast last; tuser checksum_ok
// cfg_     | in  | APB psel penable pwrite ...   | 0x0 sync_pattern, 0x4 invert_bits,
//          |     |                               | 0x8 flush_threshold
//
// One input beat per cycle while the queue has room. The back part retires one
// queued command per cycle while its output can take a beat; a gap flush holds
// it for its remaining bytes (up to 17), one beat per cycle while out_tready is high.
// Reset is synchronous, active low; no clearing pass, ready the cycle after.
// Output stalls back up through the QUEUE_DEPTH-entry command queue to in_tready.
module biphase_frame_sync_decoder import bfsd_pkg::*; #(
  parameter int unsigned FRAME_LEN   = 48,
  parameter int unsigned SYNC_BITS   = 32,
  parameter int unsigned CHECK_POS   = 45,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [0] raw_bit, [7:1] zero
  input  logic        in_tuser,     // [0] func
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,    // [5:0] byte_index, [13:6] byte_value, [15:14] zero
  output logic        out_tlast,
  output logic        out_tuser,    // [0] checksum_ok
  // config port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // register index = paddr[3:2]

  logic [31:0]      sync_pattern_r;
  logic             invert_bits_r;
  logic [10:0]      flush_thr_r;
  logic             cfg_wr;

  cmd_t             f_cmd, q_cmd;
  logic             f_valid, f_ready;
  logic             q_valid, q_ready;
  logic [IDX_W-1:0] o_idx;
  logic [7:0]       o_val;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_pattern_r <= 32'hCCCC_A64C;
      invert_bits_r  <= 1'b0;
      flush_thr_r    <= 11'd496;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_SYNC:   sync_pattern_r <= cfg_pwdata;
        REG_INVERT: invert_bits_r  <= cfg_pwdata[0];
        REG_FLUSH:  flush_thr_r    <= cfg_pwdata[10:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_SYNC:   cfg_prdata = sync_pattern_r;
      REG_INVERT: cfg_prdata = {31'd0, invert_bits_r};
      REG_FLUSH:  cfg_prdata = {21'd0, flush_thr_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // Front: bit inversion, sync hunt, frame bookkeeping, command classification
  bfsd_front #(
    .FRAME_LEN (FRAME_LEN),
    .SYNC_BITS (SYNC_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .beat_valid      (in_tvalid),
    .beat_ready      (in_tready),
    .func            (in_tuser),
    .raw_bit         (in_tdata[0]),
    .sync_pattern    (sync_pattern_r),
    .invert_bits     (invert_bits_r),
    .flush_threshold (flush_thr_r),
    .cmd_valid       (f_valid),
    .cmd_ready       (f_ready),
    .cmd             (f_cmd)
  );

  // Command queue decouples front from byte assembly and output stalls
  bfsd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_cmd)
  );

  // Back: biphase-M pair decode, byte packing, checksum, flush sequencing
  bfsd_back #(
    .FRAME_LEN (FRAME_LEN),
    .CHECK_POS (CHECK_POS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_idx   (o_idx),
    .out_val   (o_val),
    .out_last  (out_tlast),
    .out_ok    (out_tuser)
  );

  assign out_tdata = {2'b00, o_val, o_idx};

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb import bfsd_pkg::*; ();

  // Frame geometry of the instance under test
  localparam int FRAME_LEN   = 48;
  localparam int CHECK_POS   = 45;
  localparam int FRAME_RAW   = FRAME_LEN * 16;
  // A gap may only flush once this many raw bits are in the frame (max 17 bytes out)
  localparam int FLUSH_FLOOR = (FRAME_LEN - MAX_FLUSH_BYTES) * 16;
  // Settling time after the last expected beat: flush run plus command queue
  localparam int SETTLE_CYCLES = MAX_FLUSH_BYTES + 32;

  typedef struct packed {
    logic func;
    logic raw;
    logic hold;   // sender waits until every expected byte is out
  } chan_beat_t;

  typedef struct packed {
    logic [5:0] idx;
    logic [7:0] val;
    logic       last;
    logic       ok;
  } decoded_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;    // [0] raw_bit
  logic        in_tuser = 1'b0;    // [0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [5:0] byte_index, [13:6] byte_value
  logic        out_tlast;
  logic        out_tuser;          // [0] checksum_ok
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = 4'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  biphase_frame_sync_decoder DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Register shadow; only changed while the block is idle
  logic [31:0] sync_word   = 32'hCCCC_A64C;
  logic        invert_on   = 1'b0;
  logic [10:0] flush_limit = 11'd496;

  // Decoder shadow state
  logic [31:0] dec_sync    = '0;
  logic        dec_open    = 1'b0;
  logic [10:0] dec_raw_cnt = '0;
  logic        dec_half    = 1'b0;
  logic [7:0]  dec_byte    = '0;
  logic [15:0] dec_run_sum = '0;
  logic [15:0] dec_rx_sum  = '0;

  chan_beat_t    pending_bits[$];
  decoded_byte_t expected_bytes[$];
  int beats_queued = 0;
  int beats_taken  = 0;
  int mismatches   = 0;
  int send_wait    = 0;
  int take_wait    = 0;
  logic send_burst = 1'b0;
  logic take_burst = 1'b0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  // One step of the 16-bit linear frame checksum
  function automatic logic [15:0] sum_next(input logic [15:0] c, input logic [7:0] b);
    logic [7:0] rb, t, s;
    rb = {b[0], b[7:1]};
    rb = rb ^ (rb >> 2);
    t = {c[1] ^ c[3] ^ c[5], c[0] ^ c[2] ^ c[4], c[5:0]};
    s = c[14:7];
    s = s ^ (s >> 2);
    return {c[7:0], rb ^ t ^ s};
  endfunction

  task automatic push_byte();
    decoded_byte_t e;
    e.idx  = dec_raw_cnt[9:4];
    e.val  = dec_byte;
    e.last = (e.idx == FRAME_LEN - 1);
    if (e.idx < CHECK_POS) dec_run_sum = sum_next(dec_run_sum, e.val);
    if (e.idx == CHECK_POS) dec_rx_sum[15:8] = e.val;
    if (e.idx == CHECK_POS + 1) dec_rx_sum[7:0] = e.val;
    e.ok = e.last && (dec_run_sum == dec_rx_sum);
    expected_bytes.push_back(e);
  endtask

  // One raw bit inside an open frame: pairs decode biphase-M style
  task automatic decode_half(input logic hb);
    if (!dec_raw_cnt[0]) begin
      dec_half = hb;
    end else begin
      dec_byte = {dec_byte[6:0], dec_half ^ hb};
      if (dec_raw_cnt[3:0] == 4'hF) push_byte();
    end
    dec_raw_cnt++;
    if (dec_raw_cnt >= FRAME_RAW) begin
      dec_open    = 1'b0;
      dec_raw_cnt = '0;
      dec_half    = 1'b0;
    end
  endtask

  task automatic decode_beat(input logic func, input logic raw);
    logic hb;
    hb = raw ^ invert_on;
    if (func == FUNC_GAP) begin
      // gap: flush only a long enough open frame, fill with raw zeros
      if (dec_open && dec_raw_cnt > flush_limit && dec_raw_cnt >= FLUSH_FLOOR)
        while (dec_open) decode_half(1'b0);
    end else begin
      dec_sync = {dec_sync[30:0], hb};
      if (!dec_open) begin
        // the matching bit itself is not part of the frame
        if (dec_sync == sync_word || dec_sync == ~sync_word) begin
          dec_open    = 1'b1;
          dec_raw_cnt = '0;
          dec_half    = 1'b0;
          dec_byte    = '0;
          dec_run_sum = '0;
          dec_rx_sum  = '0;
        end
      end else begin
        decode_half(hb);
      end
    end
  endtask

  // Sender: presents queued beats, random gaps between them
  always @(posedge clk) begin
    chan_beat_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'd0;
      in_tuser  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_beat(in_tuser, in_tdata[0]);
        beats_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_bits.size() != 0) nxt = pending_bits[0];
        if (send_wait != 0) begin
          send_wait--;
          in_tvalid <= 1'b0;
        end else if (pending_bits.size() != 0 &&
                     !(nxt.hold && expected_bytes.size() != 0)) begin
          void'(pending_bits.pop_front());
          in_tvalid <= 1'b1;
          in_tdata  <= {7'd0, nxt.raw};
          in_tuser  <= nxt.func;
          if ($urandom_range(0, 199) == 0) send_burst = !send_burst;
          send_wait = send_burst ? 0 : $urandom_range(0, 10);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls per beat, checks against the oldest expectation
  always @(posedge clk) begin
    decoded_byte_t want, got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.idx  = out_tdata[5:0];
        got.val  = out_tdata[13:6];
        got.last = out_tlast;
        got.ok   = out_tuser;
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected beat: idx %0d val %02h last %b ok %b",
                                    got.idx, got.val, got.last, got.ok));
        end else begin
          want = expected_bytes.pop_front();
          if (got.idx !== want.idx || got.val !== want.val ||
              got.last !== want.last || got.ok !== want.ok)
            report_mismatch($sformatf(
              "expected idx %0d val %02h last %b ok %b, got idx %0d val %02h last %b ok %b",
              want.idx, want.val, want.last, want.ok, got.idx, got.val, got.last, got.ok));
        end
        if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
        take_wait = take_burst ? 0 : $urandom_range(0, 10);
      end else if (take_wait != 0) begin
        take_wait--;
      end
      out_tready <= (take_wait == 0);
    end
  end

  // APB write: setup then access; register takes it on the access edge
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_SYNC:   sync_word = val;
      REG_INVERT: invert_on = val[0];
      default:    flush_limit = val[10:0];
    endcase
  endtask

  task automatic queue_beat(input logic func, input logic raw, input logic hold);
    chan_beat_t it;
    it.func = func;
    it.raw  = raw;
    it.hold = hold;
    pending_bits.push_back(it);
    beats_queued++;
  endtask

  // Random line noise with stray gap events
  task automatic queue_noise(input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 7) == 0) queue_beat(FUNC_GAP, 1'($urandom_range(0, 1)), 1'b0);
      queue_beat(FUNC_BIT, 1'($urandom_range(0, 1)), 1'b0);
    end
  endtask

  // Sync word (or its complement), as seen after the optional inversion
  task automatic queue_sync(input logic comp, input logic hold);
    logic [31:0] w;
    w = comp ? ~sync_word : sync_word;
    for (int k = 31; k >= 0; k--) queue_beat(FUNC_BIT, w[k] ^ invert_on, hold && k == 31);
  endtask

  // Frame body. cut = 0 sends all raw bits; otherwise cut raw bits then a gap,
  // with a probe gap one bit short of the cut.
  // tail_sync makes the last 32 raw bits equal the sync word.
  task automatic queue_frame(input logic good_sum, input logic tail_sync, input int cut);
    logic [7:0]  fb [FRAME_LEN];
    logic        bits_seq [FRAME_RAW];
    logic [15:0] sum;
    logic        d, r;
    int          n;
    for (int k = 0; k < FRAME_LEN; k++) fb[k] = 8'($urandom_range(0, 255));
    if (good_sum) begin
      sum = '0;
      for (int k = 0; k < CHECK_POS; k++) sum = sum_next(sum, fb[k]);
      fb[CHECK_POS]     = sum[15:8];
      fb[CHECK_POS + 1] = sum[7:0];
    end
    // data 1 -> raw pair differs, data 0 -> raw pair equal
    for (int k = 0; k < FRAME_RAW / 2; k++) begin
      d = fb[k / 8][7 - k % 8];
      r = 1'($urandom_range(0, 1));
      bits_seq[2 * k]     = r;
      bits_seq[2 * k + 1] = r ^ d;
    end
    if (tail_sync)
      for (int k = 0; k < 32; k++) bits_seq[FRAME_RAW - 32 + k] = sync_word[31 - k];
    n = (cut == 0) ? FRAME_RAW : cut;
    for (int k = 0; k < n; k++) begin
      // stray gaps only where they cannot flush
      if ((cut != 0 && k == n - 1) ||
          ((k < FLUSH_FLOOR || flush_limit >= FRAME_RAW - 1) && $urandom_range(0, 49) == 0))
        queue_beat(FUNC_GAP, 1'($urandom_range(0, 1)), 1'b0);
      queue_beat(FUNC_BIT, bits_seq[k] ^ invert_on, 1'b0);
    end
    if (cut != 0) queue_beat(FUNC_GAP, 1'b0, 1'b0);
  endtask

  // Wait until every beat is in and every byte is out, then let the block settle
  task automatic wait_idle();
    while (beats_taken != beats_queued || expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // New register setting, then noise / sync / frame sequences.
  // First frame of each phase is flushed right at the lowest legal count, if that lies in the frame.
  task automatic run_phase(input logic [31:0] sync, input logic inv, input int thr,
                           input int nframes, input logic force_hold);
    int floor_cut, cut, kind;
    wait_idle();
    cfg_write(REG_SYNC, sync);
    cfg_write(REG_INVERT, {31'd0, inv});
    cfg_write(REG_FLUSH, thr);
    floor_cut = (thr + 1 > FLUSH_FLOOR) ? thr + 1 : FLUSH_FLOOR;
    for (int f = 0; f < nframes; f++) begin
      queue_noise($urandom_range(0, 40));
      queue_sync(1'($urandom_range(0, 1)),
                 (force_hold && f == 0) || $urandom_range(0, 2) == 0);
      kind = (f == 0) ? 0 : $urandom_range(0, 2);
      if (floor_cut >= FRAME_RAW) cut = 0;
      else if (kind == 0) cut = floor_cut;
      else if (kind == 1) cut = $urandom_range(floor_cut, FRAME_RAW - 1);
      else cut = 0;
      queue_frame($urandom_range(0, 2) != 0, $urandom_range(0, 2) == 0, cut);
    end
    queue_noise($urandom_range(4, 40));
  endtask

  initial begin
    decoded_byte_t left;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed start: all-ones sync word, so its complement (all zeros) matches
    // the cleared sync register on the very first zero bit.
    cfg_write(REG_SYNC, 32'hFFFF_FFFF);
    cfg_write(REG_INVERT, 32'd0);
    cfg_write(REG_FLUSH, 32'd1536);
    queue_beat(FUNC_GAP, 1'b1, 1'b0);   // no frame open: ignored
    queue_beat(FUNC_BIT, 1'b0, 1'b0);   // opens the frame, not part of it
    queue_beat(FUNC_GAP, 1'b0, 1'b0);   // frame open, far too short to flush
    queue_frame(1'b1, 1'b0, 0);         // full frame, good checksum
    queue_beat(FUNC_BIT, 1'b0, 1'b1);   // waits until the whole frame is out
    queue_noise(12);

    // Random phases over the register extremes
    run_phase(32'hCCCC_A64C, 1'b1, 0, 3, 1'b1);
    run_phase($urandom(), 1'b0, 496, 2, 1'b0);
    run_phase(32'h0000_0000, 1'b1, $urandom_range(FLUSH_FLOOR + 1, FRAME_RAW - 8), 2, 1'b0);
    run_phase($urandom(), 1'b0, 1536, 2, 1'b0);

    // Bounded drain, then anything still expected is missing
    for (int w = 0; w < 20000 &&
         (beats_taken != beats_queued || expected_bytes.size() != 0); w++)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (expected_bytes.size() != 0) begin
      left = expected_bytes.pop_front();
      report_mismatch($sformatf("missing beat: idx %0d val %02h last %b ok %b",
                                left.idx, left.val, left.last, left.ok));
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
